// File: hw/rtl/lds_pkg.sv
// Shared types, constants and helper functions of the Laplacian detail sharpener.
`timescale 1ns / 1ps

package lds_pkg;

    // Default sizing of the line stores and the gain format
    localparam int DEF_MAX_WIDTH      = 4096;
    localparam int DEF_MAX_HEIGHT     = 4096;
    localparam int DEF_GAIN_FRAC_BITS = 8;

    // Register geometry
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int GAIN_W       = 12;
    localparam int COORD_W      = 12;
    localparam int CHAN_W       = 8;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int MIN_DIM      = 3;

    // Laplacian and product widths
    localparam int LAP_W  = 11;
    localparam int PROD_W = GAIN_W + LAP_W;
    localparam int SUM_W  = PROD_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_DETAIL_GAIN  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgba;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_red;
        logic [CHAN_W-1:0]  out_green;
        logic [CHAN_W-1:0]  out_blue;
        logic [CHAN_W-1:0]  out_alpha;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic               last_of_run;
    } t_out_word;

    // Zero reads as one, anything above the store size saturates to it.
    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned maxv);
        int unsigned r;
        r = 32'(v);
        if (r == 0) begin
            r = 1;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/laplacian_detail_sharpener.sv
// Top level of the streaming 3x3 Laplacian detail sharpener for raster RGBA pixels.
`timescale 1ns / 1ps

// Streaming 4-neighbor Laplacian sharpener. Pixels enter in raster order, one word per
// clock when nothing stalls. Each color channel of an interior pixel becomes
// center + floor(gain * (4*center - up - down - left - right) / 2^GAIN_FRAC_BITS),
// clamped to 0..255; alpha and all border pixels pass unchanged. A pixel of row y-1
// leaves when the pixel of row y in its column arrives, so row 0 produces no words and
// each pixel of the final row produces two words (the pixel above, then itself).
// Frames narrower or shorter than three pass every pixel through at once as one word.
// Sustained rate is one pixel per clock when the output does not stall, outside the
// final row, set by the middle line store, which takes one write and two reads (this
// column and the next) in each cycle; an input word passes four registered stages (line
// store read, Laplacian, gain multiply, round and clamp) before its first output word.
// Each stage advances on its own, so bubbles close up and a word waiting at the output
// does not block input until all four stages are full. Writing frame_width or
// frame_height restarts the frame at column 0, row 0; the line stores keep their
// contents and need no clearing after reset. Write the registers only while idle.
module laplacian_detail_sharpener
    import lds_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_in_word               i_word,
    // result output
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_out_word              o_word
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    localparam int RST_W = int'(eff_dim(CFG_DATA_W'(RESET_WIDTH), MAX_WIDTH));
    localparam int RST_H = int'(eff_dim(CFG_DATA_W'(RESET_HEIGHT), MAX_HEIGHT));

    // ---------------------------------------------------------------- configuration
    logic [WB-1:0]            r_w;
    logic [HB-1:0]            r_h;
    logic [CB-1:0]            r_wm1;
    logic [RB-1:0]            r_hm1;
    logic                     r_small;
    logic signed [GAIN_W-1:0] r_gain;

    logic [WB-1:0] cfg_w;
    logic [HB-1:0] cfg_h;

    // ---------------------------------------------------------------- raster position
    logic [CB-1:0] r_col;
    logic [RB-1:0] r_row;
    logic [CB-1:0] col_cur;
    logic [RB-1:0] row_cur;
    logic [CB-1:0] col_next_addr;
    logic          last_col;
    logic          last_row;
    logic          has_a;
    logic          has_b;
    logic          acc;
    t_rgba         cur;

    // ---------------------------------------------------------------- line stores
    t_rgba r_mid_mem [MAX_WIDTH];
    t_rgba r_up_mem  [MAX_WIDTH];
    t_rgba r1_mid_c;
    t_rgba r1_mid_r;
    t_rgba r1_up;
    t_rgba r_left;
    logic  up_we;

    // ---------------------------------------------------------------- stage 1
    logic          r1_v;
    t_rgba         r1_cur;
    logic [CB-1:0] r1_col;
    logic [RB-1:0] r1_row;
    logic          r1_small;
    logic          r1_has_b;
    logic          r1_sharp;
    logic          r1_upd;

    t_rgba                   s1_center;
    logic signed [LAP_W-1:0] s1_lap [3];
    logic [CHAN_W-1:0]       s1_c   [3];
    logic [CHAN_W-1:0]       s1_u   [3];
    logic [CHAN_W-1:0]       s1_d   [3];
    logic [CHAN_W-1:0]       s1_l   [3];
    logic [CHAN_W-1:0]       s1_r   [3];
    logic [CHAN_W+1:0]       s1_sum [3];

    // ---------------------------------------------------------------- stage 2
    logic                    r2_v;
    t_rgba                   r2_pix_a;
    t_rgba                   r2_pix_b;
    logic signed [LAP_W-1:0] r2_lap [3];
    logic                    r2_sharp;
    logic                    r2_has_b;
    logic [CB-1:0]           r2_col;
    logic [RB-1:0]           r2_row_a;
    logic [RB-1:0]           r2_row_b;

    // ---------------------------------------------------------------- stage 3
    logic                     r3_v;
    t_rgba                    r3_pix_a;
    t_rgba                    r3_pix_b;
    logic signed [PROD_W-1:0] r3_prod [3];
    logic                     r3_sharp;
    logic                     r3_has_b;
    logic [CB-1:0]            r3_col;
    logic [RB-1:0]            r3_row_a;
    logic [RB-1:0]            r3_row_b;

    logic signed [PROD_W-1:0] s3_shift [3];
    logic signed [SUM_W-1:0]  s3_sum   [3];
    logic [CHAN_W-1:0]        s3_chan  [3];
    t_rgba                    s3_pix;

    // ---------------------------------------------------------------- output register
    logic          r4_v;
    logic          r4_second;
    t_rgba         r4_pix_a;
    t_rgba         r4_pix_b;
    logic          r4_has_b;
    logic [CB-1:0] r4_col;
    logic [RB-1:0] r4_row_a;
    logic [RB-1:0] r4_row_b;
    t_rgba         out_pix;
    logic          last_word;

    // ---------------------------------------------------------------- flow control
    logic s4_done, s4_free;
    logic s3_go, s3_free;
    logic s2_go, s2_free;
    logic s1_go, s1_free;

    assign last_word = r4_second || !r4_has_b;
    assign s4_done   = r4_v && !i_stall && last_word;
    assign s4_free   = !r4_v || s4_done;
    assign s3_go     = r3_v && s4_free;
    assign s3_free   = !r3_v || s4_free;
    assign s2_go     = r2_v && s3_free;
    assign s2_free   = !r2_v || s3_free;
    assign s1_go     = r1_v && s2_free;
    assign s1_free   = !r1_v || s2_free;

    assign o_stall = !s1_free;
    assign acc     = i_valid && s1_free;

    // ---------------------------------------------------------------- config writes
    assign cfg_w = WB'(eff_dim(i_cfg_data, MAX_WIDTH));
    assign cfg_h = HB'(eff_dim(i_cfg_data, MAX_HEIGHT));

    // ---------------------------------------------------------------- position decode
    always_comb begin
        cur.red   = i_word.red;
        cur.green = i_word.green;
        cur.blue  = i_word.blue;
        cur.alpha = i_word.alpha;

        // fold an out-of-range position back to the frame start
        col_cur = (32'(r_col) >= 32'(r_w)) ? '0 : r_col;
        row_cur = (32'(r_row) >= 32'(r_h)) ? '0 : r_row;
        col_next_addr = col_cur + CB'(1);

        last_col = (col_cur == r_wm1);
        last_row = (row_cur == r_hm1);
        has_a    = r_small || (row_cur != '0);
        has_b    = !r_small && last_row;
    end

    // Advance the raster position; a geometry write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= WB'(RST_W);
            r_h     <= HB'(RST_H);
            r_wm1   <= CB'(RST_W - 1);
            r_hm1   <= RB'(RST_H - 1);
            r_small <= (RST_W < MIN_DIM) || (RST_H < MIN_DIM);
            r_gain  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (acc) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : row_cur + RB'(1);
                end else begin
                    r_col <= col_cur + CB'(1);
                    r_row <= row_cur;
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_w     <= cfg_w;
                        r_wm1   <= CB'(cfg_w - WB'(1));
                        r_small <= (cfg_w < WB'(MIN_DIM)) || (r_h < HB'(MIN_DIM));
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_h     <= cfg_h;
                        r_hm1   <= RB'(cfg_h - HB'(1));
                        r_small <= (r_w < WB'(MIN_DIM)) || (cfg_h < HB'(MIN_DIM));
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    CFG_DETAIL_GAIN: begin
                        r_gain <= $signed(i_cfg_data[GAIN_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Middle line: write the new pixel, read this column (old value) and the next.
    always_ff @(posedge i_clk) begin
        if (acc && !r_small) begin
            r_mid_mem[col_cur] <= cur;
            r1_mid_c           <= r_mid_mem[col_cur];
            r1_mid_r           <= r_mid_mem[col_next_addr];
        end
    end

    // Upper line: read at accept, write back the old middle pixel as stage 1 retires.
    assign up_we = s1_go && r1_upd;

    always_ff @(posedge i_clk) begin
        if (acc && !r_small) begin
            r1_up <= r_up_mem[col_cur];
        end
        if (up_we) begin
            r_up_mem[r1_col] <= r1_mid_c;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Drop items that make no word (row 0 of a sharpened frame) right here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (acc) begin
            r1_v <= has_a;
        end else if (s1_go) begin
            r1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_cur   <= cur;
            r1_col   <= col_cur;
            r1_row   <= row_cur;
            r1_small <= r_small;
            r1_has_b <= has_b;
            r1_upd   <= !r_small && (row_cur != '0);
            r1_sharp <= !r_small && (row_cur != '0) && (row_cur != RB'(1)) &&
                        (col_cur != '0) && !last_col;
        end
    end

    // The left neighbor is the center of the previous item that left stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (up_we) begin
            r_left <= r1_mid_c;
        end
    end

    always_comb begin
        s1_center = r1_small ? r1_cur : r1_mid_c;
        s1_c[0] = s1_center.red;   s1_c[1] = s1_center.green; s1_c[2] = s1_center.blue;
        s1_u[0] = r1_up.red;       s1_u[1] = r1_up.green;     s1_u[2] = r1_up.blue;
        s1_d[0] = r1_cur.red;      s1_d[1] = r1_cur.green;    s1_d[2] = r1_cur.blue;
        s1_l[0] = r_left.red;      s1_l[1] = r_left.green;    s1_l[2] = r_left.blue;
        s1_r[0] = r1_mid_r.red;    s1_r[1] = r1_mid_r.green;  s1_r[2] = r1_mid_r.blue;
        for (int k = 0; k < 3; k++) begin
            s1_sum[k] = {2'b00, s1_u[k]} + {2'b00, s1_d[k]} +
                        {2'b00, s1_l[k]} + {2'b00, s1_r[k]};
            s1_lap[k] = $signed({1'b0, s1_c[k], 2'b00}) - $signed({1'b0, s1_sum[k]});
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (s2_free) begin
            r2_v <= s1_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r2_pix_a <= s1_center;
            r2_pix_b <= r1_cur;
            r2_lap   <= s1_lap;
            r2_sharp <= r1_sharp;
            r2_has_b <= r1_has_b;
            r2_col   <= r1_col;
            r2_row_a <= r1_small ? r1_row : r1_row - RB'(1);
            r2_row_b <= r1_row;
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (s3_free) begin
            r3_v <= s2_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            for (int k = 0; k < 3; k++) begin
                r3_prod[k] <= PROD_W'(r_gain) * PROD_W'(r2_lap[k]);
            end
            r3_pix_a <= r2_pix_a;
            r3_pix_b <= r2_pix_b;
            r3_sharp <= r2_sharp;
            r3_has_b <= r2_has_b;
            r3_col   <= r2_col;
            r3_row_a <= r2_row_a;
            r3_row_b <= r2_row_b;
        end
    end

    // Floor by arithmetic shift, add to center, clamp.
    always_comb begin
        s3_chan[0] = r3_pix_a.red;
        s3_chan[1] = r3_pix_a.green;
        s3_chan[2] = r3_pix_a.blue;
        for (int k = 0; k < 3; k++) begin
            s3_shift[k] = r3_prod[k] >>> GAIN_FRAC_BITS;
            s3_sum[k]   = SUM_W'(s3_shift[k]) + $signed({{(SUM_W-CHAN_W){1'b0}}, s3_chan[k]});
            if (s3_sum[k] < 0) begin
                s3_chan[k] = '0;
            end else if (s3_sum[k] > SUM_W'(255)) begin
                s3_chan[k] = '1;
            end else begin
                s3_chan[k] = s3_sum[k][CHAN_W-1:0];
            end
        end
        s3_pix = r3_pix_a;
        if (r3_sharp) begin
            s3_pix.red   = s3_chan[0];
            s3_pix.green = s3_chan[1];
            s3_pix.blue  = s3_chan[2];
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v      <= 1'b0;
            r4_second <= 1'b0;
        end else if (s3_go) begin
            r4_v      <= 1'b1;
            r4_second <= 1'b0;
        end else if (s4_done) begin
            r4_v      <= 1'b0;
            r4_second <= 1'b0;
        end else if (r4_v && !i_stall) begin
            // first of two words taken; show the final-row pixel next
            r4_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r4_pix_a <= s3_pix;
            r4_pix_b <= r3_pix_b;
            r4_has_b <= r3_has_b;
            r4_col   <= r3_col;
            r4_row_a <= r3_row_a;
            r4_row_b <= r3_row_b;
        end
    end

    assign out_pix = r4_second ? r4_pix_b : r4_pix_a;
    assign o_valid = r4_v;

    always_comb begin
        o_word.out_red     = out_pix.red;
        o_word.out_green   = out_pix.green;
        o_word.out_blue    = out_pix.blue;
        o_word.out_alpha   = out_pix.alpha;
        o_word.out_column  = COORD_W'(r4_col);
        o_word.out_row     = r4_second ? COORD_W'(r4_row_b) : COORD_W'(r4_row_a);
        o_word.last_of_run = last_word;
    end

    // ---------------------------------------------------------------- assertions
    a_second_needs_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_second |-> (r4_v && r4_has_b))
        else $error("second word shown for an item with one word");

    a_second_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_v && r4_second && i_stall) |=> (r4_v && r4_second))
        else $error("stalled final-row word lost");

    a_upper_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (up_we && acc && !r_small) |-> (r1_col != col_cur))
        else $error("upper line write and read hit the same column");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(r_w))
        else $error("column counter outside the frame");

endmodule

// File: sim/laplacian_detail_sharpener_tb.sv
// Self-checking testbench for the streaming Laplacian detail sharpener.
`timescale 1ns / 1ps

module laplacian_detail_sharpener_tb;
    import lds_pkg::*;

    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int MAX_H          = DEF_MAX_HEIGHT;
    localparam int GAIN_FRAC      = DEF_GAIN_FRAC_BITS;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is four stages deep
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WIDE_RUN_ITEMS = 64;
    localparam int TALL_RUN_ITEMS = 16;
    localparam int RANDOM_ITEMS   = 280;
    localparam int IDLE_PERCENT   = 13;
    localparam int PRINT_CAP      = 100;

    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;

    // Block ports
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    t_in_word               i_word      = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    t_out_word              o_word;

    // Shadow copy of the sharpener state
    logic [CFG_DATA_W-1:0]     width_reg  = CFG_DATA_W'(RESET_WIDTH);
    logic [CFG_DATA_W-1:0]     height_reg = CFG_DATA_W'(RESET_HEIGHT);
    logic signed [GAIN_W-1:0]  gain_reg   = '0;
    t_rgba                     upper_px  [MAX_W];
    t_rgba                     middle_px [MAX_W];
    t_rgba                     left_px    = '0;
    int unsigned               col_cnt    = 0;
    int unsigned               row_cnt    = 0;

    t_out_word emitted_px_q [$];   // words the block still owes, oldest first
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;
    bit        idle_on      = 1'b1;

    laplacian_detail_sharpener dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Zero counts as one, anything past the line store saturates.
    function automatic int unsigned dim_clip(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic t_rgba sharpen_px(t_rgba c, t_rgba u, t_rgba d, t_rgba l, t_rgba r,
                                         logic signed [GAIN_W-1:0] g);
        t_rgba res;
        int    gi;
        int    cc;
        int    lap;
        int    v;
        int    k;
        res = c;            // alpha rides along with the center
        gi  = g;
        for (k = 0; k < 3; k++) begin
            cc  = int'(c[CHAN_W*k +: CHAN_W]);
            lap = 4 * cc - (int'(u[CHAN_W*k +: CHAN_W]) + int'(d[CHAN_W*k +: CHAN_W]) +
                            int'(l[CHAN_W*k +: CHAN_W]) + int'(r[CHAN_W*k +: CHAN_W]));
            // arithmetic shift floors toward minus infinity
            v = cc + ((gi * lap) >>> GAIN_FRAC);
            if (v < 0) begin
                v = 0;
            end else if (v > 255) begin
                v = 255;
            end
            res[CHAN_W*k +: CHAN_W] = v[CHAN_W-1:0];
        end
        return res;
    endfunction

    function automatic t_out_word make_word(t_rgba p, int unsigned c, int unsigned r);
        t_out_word o;
        o.out_red     = p.red;
        o.out_green   = p.green;
        o.out_blue    = p.blue;
        o.out_alpha   = p.alpha;
        o.out_column  = COORD_W'(c);
        o.out_row     = COORD_W'(r);
        o.last_of_run = 1'b0;
        return o;
    endfunction

    task automatic apply_reg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH: begin
                width_reg = data;
                col_cnt   = 0;
                row_cnt   = 0;
            end
            CFG_FRAME_HEIGHT: begin
                height_reg = data;
                col_cnt    = 0;
                row_cnt    = 0;
            end
            CFG_DETAIL_GAIN: begin
                gain_reg = data[GAIN_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Advance the shadow state by one pixel and queue the words it releases.
    task automatic step_sharpener(t_in_word px);
        int unsigned wd;
        int unsigned ht;
        int unsigned c;
        int unsigned r;
        t_rgba       cur;
        t_rgba       center;
        t_rgba       res;
        t_out_word   outs [2];
        int          n;
        int          i;
        wd = dim_clip(width_reg, MAX_W);
        ht = dim_clip(height_reg, MAX_H);
        c  = col_cnt;
        r  = row_cnt;
        if (c >= wd) c = 0;
        if (r >= ht) r = 0;
        cur.red   = px.red;
        cur.green = px.green;
        cur.blue  = px.blue;
        cur.alpha = px.alpha;
        n = 0;
        if (wd < MIN_DIM || ht < MIN_DIM) begin
            // tiny frame: straight through
            outs[n] = make_word(cur, c, r);
            n++;
        end else begin
            if (r >= 1) begin
                center = middle_px[c];
                if (r == 1 || c == 0 || c == wd - 1) begin
                    res = center;
                end else begin
                    res = sharpen_px(center, upper_px[c], cur, left_px, middle_px[c + 1],
                                     gain_reg);
                end
                outs[n] = make_word(res, c, r - 1);
                n++;
                left_px     = center;
                upper_px[c] = center;
            end
            middle_px[c] = cur;
            if (r == ht - 1) begin
                outs[n] = make_word(cur, c, r);
                n++;
            end
        end
        for (i = 0; i < n; i++) begin
            outs[i].last_of_run = (i == n - 1);
            emitted_px_q.push_back(outs[i]);
        end
        c++;
        if (c >= wd) begin
            c = 0;
            r++;
            if (r >= ht) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endtask

    // Track every register write and every accepted pixel word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end else if (i_valid && !o_stall) begin
                step_sharpener(i_word);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        if (mismatch_cnt < PRINT_CAP) begin
            $display("mismatch @%0t: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    task automatic check_field(string name, int got, int want, t_out_word w);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d (col %0d row %0d)",
                                      name, got, want, w.out_column, w.out_row));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (emitted_px_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word at col %0d row %0d",
                                          o_word.out_column, o_word.out_row));
            end else begin
                want = emitted_px_q.pop_front();
                check_field("out_red",     o_word.out_red,     want.out_red,     want);
                check_field("out_green",   o_word.out_green,   want.out_green,   want);
                check_field("out_blue",    o_word.out_blue,    want.out_blue,    want);
                check_field("out_alpha",   o_word.out_alpha,   want.out_alpha,   want);
                check_field("out_column",  o_word.out_column,  want.out_column,  want);
                check_field("out_row",     o_word.out_row,     want.out_row,     want);
                check_field("last_of_run", o_word.last_of_run, want.last_of_run, want);
            end
        end
    end

    // Output side backpressure
    always @(posedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Abort when neither side moves a word for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drop valid, wait for every owed word, then let the pipeline empty.
    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (emitted_px_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        settle_pipeline();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one pixel and hold it until the block takes it.
    task automatic send_pixel(t_in_word px);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [CHAN_W-1:0] pick_chan();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return CHAN_W'($urandom_range(255));
    endfunction

    function automatic t_in_word random_pixel();
        t_in_word px;
        px.red   = pick_chan();
        px.green = pick_chan();
        px.blue  = pick_chan();
        px.alpha = pick_chan();
        return px;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 20) begin
            case ($urandom_range(4))
                0:       return 13'h0000;
                1:       return 13'h0400;   // +1024
                2:       return 13'h1C00;   // -1024, spare top bit set
                3:       return 13'h07FF;   // most positive
                default: return 13'h0800;   // most negative
            endcase
        end
        if (r < 70) return CFG_DATA_W'($urandom_range(0, 2048) - 1024);
        return CFG_DATA_W'($urandom_range(0, 8191));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default geometry, first row silence, border copies, one interior pixel, and
    // register writes in mid-frame that must not restart it.
    task automatic test_first_and_final_rows();
        t_in_word frame_px [9];
        int       i;
        frame_px = '{32'h00000000, 32'hFFFFFFFF, 32'h00FF00FF,
                     32'hFF00FF00, 32'hFFFFFF80, 32'h00000000,
                     32'h0CC8FF01, 32'h000000FF, 32'hFFFFFF00};
        // reset geometry is wide: these stay in row 0 and release nothing
        for (i = 0; i < 3; i++) begin
            send_pixel(frame_px[i]);
        end
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        write_reg(CFG_DETAIL_GAIN, 13'h07FF);
        for (i = 0; i < 4; i++) begin
            send_pixel(frame_px[i]);
        end
        // neither write below may move the frame position
        write_reg(CFG_NO_REG, 13'h1FFF);
        write_reg(CFG_DETAIL_GAIN, 13'h1800);
        for (i = 4; i < 9; i++) begin
            send_pixel(frame_px[i]);
        end
    endtask

    // Frames under three in either direction, including zero sizes.
    task automatic test_small_frames();
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'h00000000);
        send_pixel(32'h80FF0001);
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        send_pixel(32'h01020304);
        send_pixel(32'hFEFDFCFB);
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        send_pixel(32'hFF00FF00);
        send_pixel(32'h00FF00FF);
    endtask

    // Saturated width, one row: a long run of columns.
    // Runs with no idling on either side.
    task automatic test_wide_row();
        int i;
        write_reg(CFG_FRAME_WIDTH, 13'd4097);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        idle_on = 1'b0;
        for (i = 0; i < WIDE_RUN_ITEMS; i++) begin
            send_pixel(random_pixel());
        end
        idle_on = 1'b1;
    endtask

    // Saturated height, one column: a run of row numbers.
    task automatic test_tall_column();
        int i;
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        for (i = 0; i < TALL_RUN_ITEMS; i++) begin
            send_pixel(random_pixel());
        end
    endtask

    // Mostly whole frames of random size and content, some cut short,
    // with gain changes between frames and inside them, and ignored writes inside them.
    task automatic test_random_frames();
        int w;
        int h;
        int n;
        int i;
        int sent;
        int r;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(99) < 12) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            h = ($urandom_range(99) < 12) ? $urandom_range(1, 2) : $urandom_range(3, 6);
            write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
            write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
            if ($urandom_range(99) < 60) begin
                write_reg(CFG_DETAIL_GAIN, pick_gain());
            end
            // one frame or two back to back, so the row counter wraps by itself
            n = w * h * $urandom_range(1, 2);
            // now and then stop mid-frame; the next geometry write restarts it
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, n);
            end
            for (i = 0; i < n; i++) begin
                r = $urandom_range(99);
                if (r < 2) begin
                    write_reg(CFG_DETAIL_GAIN, pick_gain());
                end else if (r < 3) begin
                    write_reg(CFG_NO_REG, CFG_DATA_W'($urandom_range(0, 8191)));
                end
                send_pixel(random_pixel());
                sent++;
                // hold off once until the block has caught up completely
                if (!paused && sent >= RANDOM_ITEMS / 2) begin
                    settle_pipeline();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_and_final_rows();
        test_small_frames();
        test_wide_row();
        test_tall_column();
        test_random_frames();
        settle_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (emitted_px_q.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", emitted_px_q.size()));
        end
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lds_pkg.sv
hw/rtl/laplacian_detail_sharpener.sv
sim/laplacian_detail_sharpener_tb.sv
